/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted (active-low reset).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lfhs_pkg.sv */
// ----------------------------------------------------------------------------
// lfhs_pkg
// Widths, register codes, reset values, constants and shared types of the free heading selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lfhs_pkg;

    localparam int RANGE_W    = 16;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int HW_W       = 11;
    localparam int STEP_W     = 17;
    localparam int SPEED_W    = 14;
    localparam int HEAD_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP      = 2'd3;

    localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = 13'd720;
    localparam logic [HW_W-1:0]    RST_HALF_WINDOW  = 11'd30;
    localparam logic [RANGE_W-1:0] RST_THRESHOLD    = 16'd5000;
    localparam logic [STEP_W-1:0]  RST_ANGLE_STEP   = 17'd4363;

    localparam logic [SPEED_W-1:0] STRAIGHT_SPEED = 14'd2000;

    // floor(x / 5) == (x * 52429) >> 18 for every 16-bit x
    localparam int               DIV5_W     = 17;
    localparam logic [DIV5_W-1:0] DIV5_MULT = 17'd52429;
    localparam int               DIV5_SHIFT = 18;

    typedef struct packed {
        logic [CNT_W-1:0]   sample_count;
        logic [HW_W-1:0]    half_window;
        logic [RANGE_W-1:0] threshold;
        logic [STEP_W-1:0]  angle_step;
    } t_cfg;

    // Selected direction of a finished scan, handed to the heading stage
    typedef struct packed {
        logic               valid;
        logic               path_clear;
        logic               no_free;
        logic [IDX_W-1:0]   chosen_index;
        logic [RANGE_W-1:0] chosen_range;
    } t_sel;

    function automatic logic [IDX_W-1:0] half_of(input t_cfg cfg);
        return cfg.sample_count[CNT_W-1:1];
    endfunction

endpackage

`default_nettype wire

/* rtl/lfhs_in_if.sv */
// ----------------------------------------------------------------------------
// lfhs_in_if
// Range sample channel: valid/ready with one lidar sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfhs_in_if
    import lfhs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               scan_last;

    modport source (output valid, output range_mm, output scan_last, input ready);
    modport sink   (input valid, input range_mm, input scan_last, output ready);
endinterface

`default_nettype wire

/* rtl/lfhs_out_if.sv */
// ----------------------------------------------------------------------------
// lfhs_out_if
// Heading result channel: valid/ready with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfhs_out_if
    import lfhs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [SPEED_W-1:0]       speed_mm;
    logic signed [HEAD_W-1:0] heading_urad;
    logic [IDX_W-1:0]         chosen_index;
    logic                     path_clear;
    logic                     no_free_direction;

    modport source (
        output valid, output speed_mm, output heading_urad, output chosen_index,
        output path_clear, output no_free_direction, input ready
    );
    modport sink (
        input valid, input speed_mm, input heading_urad, input chosen_index,
        input path_clear, input no_free_direction, output ready
    );
endinterface

`default_nettype wire

/* rtl/lfhs_scan_track.sv */
// ----------------------------------------------------------------------------
// lfhs_scan_track
// Input register, per-scan tracking state and side selection.
// ----------------------------------------------------------------------------
`default_nettype none

module lfhs_scan_track
    import lfhs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    lfhs_in_if.sink    i_in,
    output t_sel       o_sel,
    input  wire logic  i_sel_ready
);

    logic               r_in_valid;
    logic [RANGE_W-1:0] r_in_range;
    logic               r_in_last;

    logic               idx_sat;
    logic [IDX_W-1:0]   r_idx;
    logic               r_blocked;
    logic               r_up_found;
    logic [IDX_W-1:0]   r_up_idx;
    logic [RANGE_W-1:0] r_up_range;
    logic               r_lo_found;
    logic [IDX_W-1:0]   r_lo_idx;
    logic [RANGE_W-1:0] r_lo_range;

    logic               n_blocked;
    logic               n_up_found;
    logic [IDX_W-1:0]   n_up_idx;
    logic [RANGE_W-1:0] n_up_range;
    logic               n_lo_found;
    logic [IDX_W-1:0]   n_lo_idx;
    logic [RANGE_W-1:0] n_lo_range;
    t_sel               n_sel;
    t_sel               r_sel;

    logic               sel_free;
    logic               consume;
    logic [IDX_W-1:0]   half;
    logic [CNT_W-1:0]   idx_x;
    logic [CNT_W-1:0]   half_x;
    logic [CNT_W-1:0]   idx_plus_w;
    logic [CNT_W-1:0]   half_plus_w;
    logic               in_use;
    logic               is_clear;
    logic               in_win;
    logic               up_hit;
    logic               lo_hit;
    logic [IDX_W-1:0]   up_off;
    logic [IDX_W-1:0]   lo_off;
    logic               take_upper;

    assign sel_free   = !r_sel.valid || i_sel_ready;
    // non-last samples only touch the tracking state; last ones need a free slot
    assign consume    = r_in_valid && (!r_in_last || sel_free);
    assign i_in.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_range <= i_in.range_mm;
            r_in_last  <= i_in.scan_last;
        end
    end

    assign half        = half_of(i_cfg);
    assign idx_x       = {1'b0, r_idx};
    assign half_x      = {1'b0, half};
    assign idx_plus_w  = idx_x + {{(CNT_W-HW_W){1'b0}}, i_cfg.half_window};
    assign half_plus_w = half_x + {{(CNT_W-HW_W){1'b0}}, i_cfg.half_window};

    assign in_use   = idx_x < i_cfg.sample_count;
    assign is_clear = r_in_range > i_cfg.threshold;
    // idx + w >= half stands for idx >= half - w without going negative
    assign in_win   = in_use && (idx_plus_w >= half_x) && (idx_x < half_plus_w);
    assign up_hit   = in_use && (idx_x >= half_plus_w) && is_clear && !r_up_found;
    assign lo_hit   = in_use && (idx_plus_w <= half_x) && is_clear;

    always_comb begin
        n_blocked  = r_blocked || (in_win && !is_clear);
        n_up_found = r_up_found || up_hit;
        n_up_idx   = up_hit ? r_idx : r_up_idx;
        n_up_range = up_hit ? r_in_range : r_up_range;
        n_lo_found = r_lo_found || lo_hit;
        n_lo_idx   = lo_hit ? r_idx : r_lo_idx;
        n_lo_range = lo_hit ? r_in_range : r_lo_range;
    end

    assign up_off     = n_up_idx - half;
    assign lo_off     = half - n_lo_idx;
    assign take_upper = n_up_found && (!n_lo_found || (up_off <= lo_off));

    always_comb begin
        n_sel.valid      = consume && r_in_last;
        n_sel.path_clear = !n_blocked;
        n_sel.no_free    = n_blocked && !n_up_found && !n_lo_found;
        if (!n_blocked || n_sel.no_free) begin
            n_sel.chosen_index = half;
            n_sel.chosen_range = n_up_range;
        end else if (take_upper) begin
            n_sel.chosen_index = n_up_idx;
            n_sel.chosen_range = n_up_range;
        end else begin
            n_sel.chosen_index = n_lo_idx;
            n_sel.chosen_range = n_lo_range;
        end
    end

    assign idx_sat = &r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_blocked  <= 1'b0;
            r_up_found <= 1'b0;
            r_up_idx   <= '0;
            r_up_range <= '0;
            r_lo_found <= 1'b0;
            r_lo_idx   <= '0;
            r_lo_range <= '0;
        end else if (consume) begin
            if (r_in_last) begin
                r_idx      <= '0;
                r_blocked  <= 1'b0;
                r_up_found <= 1'b0;
                r_up_idx   <= '0;
                r_up_range <= '0;
                r_lo_found <= 1'b0;
                r_lo_idx   <= '0;
                r_lo_range <= '0;
            end else begin
                r_idx      <= idx_sat ? r_idx : r_idx + 1'b1;
                r_blocked  <= n_blocked;
                r_up_found <= n_up_found;
                r_up_idx   <= n_up_idx;
                r_up_range <= n_up_range;
                r_lo_found <= n_lo_found;
                r_lo_idx   <= n_lo_idx;
                r_lo_range <= n_lo_range;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel.valid <= 1'b0;
        end else if (sel_free) begin
            r_sel <= n_sel;
        end
    end

    assign o_sel = r_sel;

endmodule

`default_nettype wire

/* rtl/lfhs_heading_calc.sv */
// ----------------------------------------------------------------------------
// lfhs_heading_calc
// Speed (range / 5 on a side pick, else straight speed or zero) and heading (offset * step) with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfhs_heading_calc
    import lfhs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_sel  i_sel,
    output logic       o_sel_ready,
    lfhs_out_if.source o_out
);

    localparam int QUOT_PROD_W = RANGE_W + DIV5_W;
    localparam int OFF_W       = IDX_W + 1;
    localparam int HEAD_PROD_W = OFF_W + STEP_W + 1;

    logic                          r_out_valid;
    logic [SPEED_W-1:0]            r_speed;
    logic signed [HEAD_W-1:0]      r_heading;
    logic [IDX_W-1:0]              r_chosen;
    logic                          r_path_clear;
    logic                          r_no_free;

    logic                          en;
    logic [QUOT_PROD_W-1:0]        quot_prod;
    logic [SPEED_W-1:0]            quot;
    logic [SPEED_W-1:0]            n_speed;
    logic signed [OFF_W-1:0]       offset;
    logic signed [HEAD_PROD_W-1:0] head_prod;

    assign en          = !r_out_valid || o_out.ready;
    assign o_sel_ready = en;

    assign quot_prod = i_sel.chosen_range * DIV5_MULT;
    assign quot      = quot_prod[DIV5_SHIFT +: SPEED_W];

    always_comb begin
        if (i_sel.path_clear) begin
            n_speed = STRAIGHT_SPEED;
        end else if (i_sel.no_free) begin
            n_speed = '0;
        end else begin
            n_speed = quot;
        end
    end

    // straight and stop carry chosen == half, so the offset is zero there
    assign offset    = $signed({1'b0, i_sel.chosen_index}) - $signed({1'b0, half_of(i_cfg)});
    assign head_prod = offset * $signed({1'b0, i_cfg.angle_step});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= i_sel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_sel.valid) begin
            r_speed      <= n_speed;
            r_heading    <= head_prod[HEAD_W-1:0];
            r_chosen     <= i_sel.chosen_index;
            r_path_clear <= i_sel.path_clear;
            r_no_free    <= i_sel.no_free;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.speed_mm          = r_speed;
    assign o_out.heading_urad      = r_heading;
    assign o_out.chosen_index      = r_chosen;
    assign o_out.path_clear        = r_path_clear;
    assign o_out.no_free_direction = r_no_free;

endmodule

`default_nettype wire

/* rtl/lidar_free_heading_select.sv */
// ----------------------------------------------------------------------------
// lidar_free_heading_select
// Picks a free heading from one lidar scan streamed sample by sample.
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        range_mm, scan_last
//   o_out    out  valid/ready        speed_mm, heading_urad, chosen_index,
//                                    path_clear, no_free_direction
//   i_cfg_*  in   write enable only  register index, write data
//
// One sample per cycle sustained unless a final sample waits for the select
// slot; a scan's result goes through the select register, then the result register.
// The divide-by-5 and angle multiplies sit in the last stage.
// A stalled result backs up into the select register; non-final samples still
// update the tracking state, a final sample waits until the select slot frees.
// Synchronous reset clears pipeline valids and tracking state and loads the config defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lidar_free_heading_select
    import lfhs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lfhs_in_if.sink                    i_in,
    lfhs_out_if.source                 o_out
);

    t_cfg r_cfg;
    t_sel w_sel;
    logic w_sel_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count <= RST_SAMPLE_COUNT;
            r_cfg.half_window  <= RST_HALF_WINDOW;
            r_cfg.threshold    <= RST_THRESHOLD;
            r_cfg.angle_step   <= RST_ANGLE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_COUNT:    r_cfg.sample_count <= i_cfg_data[CNT_W-1:0];
                CFG_HALF_WINDOW:     r_cfg.half_window  <= i_cfg_data[HW_W-1:0];
                CFG_CLEAR_THRESHOLD: r_cfg.threshold    <= i_cfg_data[RANGE_W-1:0];
                CFG_ANGLE_STEP:      r_cfg.angle_step   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    lfhs_scan_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_sel       (w_sel),
        .i_sel_ready (w_sel_ready)
    );

    lfhs_heading_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_sel       (w_sel),
        .o_sel_ready (w_sel_ready),
        .o_out       (o_out)
    );

    `ASSERT_RST(a_straight_centre, i_clk, i_rst_n, (o_out.valid && o_out.path_clear) |-> (o_out.heading_urad == 0 && o_out.chosen_index == half_of(r_cfg)), "straight result off centre")
    `ASSERT_RST(a_stop_result, i_clk, i_rst_n, (o_out.valid && o_out.no_free_direction) |-> (o_out.speed_mm == 0 && !o_out.path_clear && o_out.heading_urad == 0), "stop result inconsistent")
    `ASSERT_RST(a_sel_held, i_clk, i_rst_n, (w_sel.valid && !w_sel_ready) |=> (w_sel.valid && $stable(w_sel.chosen_index)), "select stage dropped under stall")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the free heading selector against a scan-level predictor. Samples
// are streamed as whole scans under random sender bursts and receiver stalls.
// A short directed table covers reset values, stop, straight and side choice.
// Random phases then reprogram the registers and run scans around the
// threshold.
// ----------------------------------------------------------------------------

module tb_top
    import lfhs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1430;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_IDX      = (1 << IDX_W) - 1;
    localparam int RANGE_MAX    = (1 << RANGE_W) - 1;
    localparam int SPEED_DIV    = 5;
    localparam int PRESSURE_PHASE = 4;
    localparam int N_DIR        = 20;
    localparam int DIR_CFG_ROW  = 1;

    localparam int COUNT_EDGES [5] = '{0, 1, 2, 4096, 8191};
    localparam int STEP_EDGES  [4] = '{0, 1, 100000, 131071};

    typedef struct packed {
        logic [SPEED_W-1:0]       speed_mm;
        logic signed [HEAD_W-1:0] heading_urad;
        logic [IDX_W-1:0]         chosen_index;
        logic                     path_clear;
        logic                     no_free;
    } heading_t;

    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic               last;
        logic               typed;
        heading_t           want;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_RARE} rx_mode_e;

    // Row 0 runs on reset values; the rest use count 4, window 1, threshold 100,
    // step 1000 (half 2, window [1,3), upper side from 3, lower side up to 1).
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{16'd0,     1'b1, 1'b1, '{14'd2000, 30'sd0, 12'd360, 1'b1, 1'b0}},
        // all clear: straight ahead
        '{16'd65535, 1'b0, 1'b0, '0},
        '{16'd65535, 1'b0, 1'b0, '0},
        '{16'd65535, 1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b1, '{14'd2000, 30'sd0, 12'd2, 1'b1, 1'b0}},
        // all blocked: stop
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b1, 1'b1, '{14'd0, 30'sd0, 12'd2, 1'b0, 1'b1}},
        // equal offsets on both sides: upper wins
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd101,   1'b0, 1'b0, '0},
        '{16'd100,   1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b1, '{14'd13107, 30'sd1000, 12'd3, 1'b0, 1'b0}},
        // lower side only, sample past the count is ignored
        '{16'd600,   1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b0, '0},
        // scan ends before the window is complete
        '{16'd0,     1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfhs_in_if  in_ch ();
    lfhs_out_if out_ch ();

    lidar_free_heading_select u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register shadow and per-scan tracking state
    logic [CNT_W-1:0]   cfg_count;
    logic [HW_W-1:0]    cfg_window;
    logic [RANGE_W-1:0] cfg_thr;
    logic [STEP_W-1:0]  cfg_step;

    logic [IDX_W-1:0]   scan_idx;
    logic               win_blocked;
    logic               up_found;
    logic [IDX_W-1:0]   up_idx;
    logic [RANGE_W-1:0] up_rng;
    logic               lo_found;
    logic [IDX_W-1:0]   lo_idx;
    logic [RANGE_W-1:0] lo_rng;

    heading_t heading_q [$];
    int       mismatches   = 0;
    int       cycles       = 0;
    int       hold_reqs    = 0;
    int       burst_left   = 0;
    bit       gaps_on      = 1'b1;

    task automatic clear_scan_state();
        scan_idx    = '0;
        win_blocked = 1'b0;
        up_found    = 1'b0;
        up_idx      = '0;
        up_rng      = '0;
        lo_found    = 1'b0;
        lo_idx      = '0;
        lo_rng      = '0;
    endtask

    task automatic track_sample(input logic [RANGE_W-1:0] rng, input logic last,
                                output bit produced, output heading_t res);
        int     half;
        int     win;
        int     idx;
        bit     is_free;
        bit     take_upper;
        longint offset;
        longint prod;
        half     = int'(cfg_count >> 1);
        win      = int'(cfg_window);
        idx      = int'(scan_idx);
        is_free  = rng > cfg_thr;
        produced = last;
        res      = '0;
        if (idx < int'(cfg_count)) begin
            if (idx >= half - win && idx < half + win && !is_free)
                win_blocked = 1'b1;
            if (idx >= half + win && is_free && !up_found) begin
                up_found = 1'b1;
                up_idx   = scan_idx;
                up_rng   = rng;
            end
            if (idx <= half - win && is_free) begin
                lo_found = 1'b1;
                lo_idx   = scan_idx;
                lo_rng   = rng;
            end
        end
        if (idx < MAX_IDX)
            scan_idx = scan_idx + 1'b1;
        if (last) begin
            offset           = 0;
            res.chosen_index = IDX_W'(half);
            res.path_clear   = !win_blocked;
            if (!win_blocked) begin
                res.speed_mm = STRAIGHT_SPEED;
            end else if (!up_found && !lo_found) begin
                res.no_free = 1'b1;
            end else begin
                if (up_found && lo_found)
                    take_upper = (int'(up_idx) - half) <= (half - int'(lo_idx));
                else
                    take_upper = up_found;
                if (take_upper) begin
                    res.chosen_index = up_idx;
                    res.speed_mm     = SPEED_W'(int'(up_rng) / SPEED_DIV);
                end else begin
                    res.chosen_index = lo_idx;
                    res.speed_mm     = SPEED_W'(int'(lo_rng) / SPEED_DIV);
                end
                offset = longint'(res.chosen_index) - longint'(half);
            end
            prod             = offset * longint'(cfg_step);
            res.heading_urad = prod[HEAD_W-1:0];
            clear_scan_state();
        end
    endtask

    // Drive one sample and wait for its transaction; the sender may idle between bursts while gaps are on.
    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic last,
                               input logic typed, input heading_t want);
        bit       produced;
        heading_t res;
        int       gap;
        if (burst_left == 0) begin
            gap = gaps_on ? int'($urandom_range(0, 8)) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 150))
                                                     : int'($urandom_range(1, 12));
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.range_mm  <= rng;
        in_ch.scan_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_sample(rng, last, produced, res);
        if (produced)
            heading_q.push_back(typed ? want : res);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SAMPLE_COUNT:    cfg_count  = data[CNT_W-1:0];
            CFG_HALF_WINDOW:     cfg_window = data[HW_W-1:0];
            CFG_CLEAR_THRESHOLD: cfg_thr    = data[RANGE_W-1:0];
            CFG_ANGLE_STEP:      cfg_step   = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits above the count, window and threshold widths carry junk; they must be dropped.
    task automatic program_scan(input logic [CNT_W-1:0] count, input logic [HW_W-1:0] win,
                                input logic [RANGE_W-1:0] thr, input logic [STEP_W-1:0] step);
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(count) | (CFG_DATA_W'($urandom) << CNT_W));
        write_reg(CFG_HALF_WINDOW, CFG_DATA_W'(win) | (CFG_DATA_W'($urandom) << HW_W));
        write_reg(CFG_CLEAR_THRESHOLD, CFG_DATA_W'(thr) | (CFG_DATA_W'($urandom) << RANGE_W));
        write_reg(CFG_ANGLE_STEP, CFG_DATA_W'(step));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [RANGE_W-1:0] pick_range(input int unsigned pct);
        int unsigned thr;
        thr = cfg_thr;
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return cfg_thr;
            3: return (thr == RANGE_MAX) ? cfg_thr : cfg_thr + 1'b1;
            default: begin
                if ($urandom_range(1, 100) <= pct && thr < RANGE_MAX)
                    return RANGE_W'($urandom_range(RANGE_MAX, thr + 1));
                return RANGE_W'($urandom_range(thr, 0));
            end
        endcase
    endfunction

    // result checker and receiver stall pattern
    initial begin
        heading_t got;
        heading_t want;
        rx_mode_e rx_mode;
        int       rx_tick;
        int       hold_done;
        int       hold_left;
        rx_mode      = RX_OPEN;
        rx_tick      = 0;
        hold_done    = 0;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.speed_mm     = out_ch.speed_mm;
                got.heading_urad = out_ch.heading_urad;
                got.chosen_index = out_ch.chosen_index;
                got.path_clear   = out_ch.path_clear;
                got.no_free      = out_ch.no_free_direction;
                if (heading_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: speed %0d heading %0d index %0d clear %0b stop %0b",
                             $time, got.speed_mm, got.heading_urad, got.chosen_index,
                             got.path_clear, got.no_free);
                end else begin
                    want = heading_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected speed %0d heading %0d index %0d clear %0b stop %0b",
                                 $time, want.speed_mm, want.heading_urad, want.chosen_index,
                                 want.path_clear, want.no_free);
                        $display("%0t: actual   speed %0d heading %0d index %0d clear %0b stop %0b",
                                 $time, got.speed_mm, got.heading_urad, got.chosen_index,
                                 got.path_clear, got.no_free);
                    end
                end
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_done != hold_reqs) begin
                hold_done++;
                hold_left = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end else begin
                if (rx_tick % 128 == 0)
                    rx_mode = rx_mode_e'($urandom_range(0, 3));
                case (rx_mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: out_ch.ready <= (rx_tick % 4) != 3;
                    default:   out_ch.ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned      phase;
        int unsigned      n_scans;
        int unsigned      scan_len;
        int unsigned      pct;
        int               random_items;
        logic [CNT_W-1:0]   p_count;
        logic [HW_W-1:0]    p_win;
        logic [RANGE_W-1:0] p_thr;
        logic [STEP_W-1:0]  p_step;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SAMPLE_COUNT;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.range_mm  <= '0;
        in_ch.scan_last <= 1'b0;
        cfg_count  = RST_SAMPLE_COUNT;
        cfg_window = RST_HALF_WINDOW;
        cfg_thr    = RST_THRESHOLD;
        cfg_step   = RST_ANGLE_STEP;
        clear_scan_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (i == DIR_CFG_ROW) begin
                wait_idle();
                program_scan(13'd4, 11'd1, 16'd100, 17'd1000);
            end
            send_sample(DIR_ROWS[i].rng, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                        DIR_ROWS[i].want);
        end

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            n_scans = $urandom_range(4, 20);
            case (phase)
                0: begin
                    p_count = 13'd2; p_win = 11'd0; p_thr = 16'd0; p_step = 17'd1;
                end
                1: begin
                    p_count = 13'd3; p_win = 11'd2047; p_thr = 16'hFFFF; p_step = 17'd131071;
                end
                2: begin
                    p_count = 13'd0; p_win = 11'd1; p_thr = 16'd1000; p_step = 17'd0;
                end
                3: begin
                    p_count = 13'd1; p_win = 11'd0; p_thr = 16'd30000; p_step = 17'd100000;
                end
                PRESSURE_PHASE: begin
                    p_count = 13'd2; p_win = 11'd1; p_thr = 16'd30000; p_step = 17'd4363;
                    n_scans = 60;
                end
                default: begin
                    p_count = ($urandom_range(0, 9) == 0) ? CNT_W'(COUNT_EDGES[$urandom_range(0, 4)])
                                                          : CNT_W'($urandom_range(2, 24));
                    if ($urandom_range(0, 9) == 0)
                        p_win = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
                    else
                        p_win = HW_W'($urandom_range(0, (p_count % 64) / 2 + 2));
                    if ($urandom_range(0, 9) == 0)
                        p_thr = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                    else
                        p_thr = RANGE_W'($urandom);
                    p_step = ($urandom_range(0, 9) == 0) ? STEP_W'(STEP_EDGES[$urandom_range(0, 3)])
                                                         : STEP_W'($urandom_range(1, 100000));
                end
            endcase
            program_scan(p_count, p_win, p_thr, p_step);
            gaps_on = (phase % 3) != 2;
            if (phase == PRESSURE_PHASE) begin
                // receiver holds off while short scans keep coming
                hold_reqs++;
                gaps_on = 1'b0;
            end
            repeat (n_scans) begin
                if (random_items >= RANDOM_ITEMS)
                    break;
                if (cfg_count == 0)
                    scan_len = $urandom_range(1, 4);
                else if (cfg_count > 48)
                    scan_len = $urandom_range(1, 48);
                else begin
                    case ($urandom_range(0, 6))
                        0:       scan_len = $urandom_range(1, cfg_count);
                        1:       scan_len = cfg_count + $urandom_range(1, 4);
                        default: scan_len = cfg_count;
                    endcase
                end
                case ($urandom_range(0, 4))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 70;
                    3:       pct = 95;
                    default: pct = 100;
                endcase
                for (int k = 0; k < int'(scan_len); k++) begin
                    send_sample(pick_range(pct), k == int'(scan_len) - 1, 1'b0, '0);
                    random_items++;
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
